// File: sv/x86alu_pkg.sv
`default_nettype none

package x86alu_pkg;

    localparam int unsigned InDataW  = 72;
    localparam int unsigned OutDataW = 40;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_ADC  = 4'd1,
        CMD_SUB  = 4'd2,
        CMD_SBB  = 4'd3,
        CMD_CMP  = 4'd4,
        CMD_AND  = 4'd5,
        CMD_TEST = 4'd6,
        CMD_OR   = 4'd7,
        CMD_XOR  = 4'd8,
        CMD_NOT  = 4'd9,
        CMD_ROL  = 4'd10,
        CMD_ROR  = 4'd11,
        CMD_SAR  = 4'd12,
        CMD_SHL  = 4'd13,
        CMD_SHR  = 4'd14,
        CMD_IMUL = 4'd15
    } cmd_t;

    typedef enum logic [1:0] {
        WC_BYTE  = 2'd0,
        WC_WORD  = 2'd1,
        WC_DWORD = 2'd2,
        WC_BAD   = 2'd3
    } width_t;

    // cf in the lowest bit
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic pf;
        logic cf;
    } flags_t;

    // packed to match the output tdata layout, result in the lowest bits
    typedef struct packed {
        logic        error;
        flags_t      flags;
        logic        writes_result;
        logic [31:0] result;
    } exec_res_t;

endpackage

`default_nettype wire

// File: sv/x86_integer_alu_with_flags_core.sv
// x86 integer ALU, 8/16/32-bit, with a stored CF/PF/ZF/SF/OF register.
// Slave channel (s_*) carries one operation per transaction; master channel
// (m_*) returns exactly one result per operation, in order.
// A transaction accepted on s_* is captured in the input register and executed
// from it; its result is loaded into the result register and offered on m_*.
// Throughput: one operation per cycle while the receiver does not stall. The
// execute path is the input register, one pass through the adder / shifter /
// 32x32 multiplier, and the result register; the flag register is written in
// the same edge that loads the result register, so adc and sbb see the carry
// of the item straight before them.
// When the receiver stalls, the result register holds its transaction and
// one further operation waits in the input register; s_tready then drops.
// Reset clears both valid bits and all five flags.
`default_nettype none

module x86_integer_alu_with_flags_core
    import x86alu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    // [3:0] command, [5:4] width_code, [37:6] operand_a, [69:38] operand_b
    input  wire logic [InDataW-1:0]  s_tdata,
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    // [31:0] result, [32] writes_result, [33] carry_out, [34] parity_out,
    // [35] zero_out, [36] sign_out, [37] overflow_out, [38] error
    output      logic [OutDataW-1:0] m_tdata
);

    logic        in_valid_reg;
    logic        in_valid_next;
    cmd_t        cmd_reg;
    width_t      width_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    exec_res_t   out_reg;
    flags_t      flags_reg;
    flags_t      flags_next;
    exec_res_t   exec_res;
    logic        advance;
    logic        in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    x86alu_exec u_exec (
        .command    (cmd_reg),
        .width_code (width_reg),
        .operand_a  (a_reg),
        .operand_b  (b_reg),
        .flags_in   (flags_reg),
        .res_out    (exec_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;

        flags_next = advance ? exec_res.flags : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= cmd_t'(s_tdata[3:0]);
            width_reg <= width_t'(s_tdata[5:4]);
            a_reg     <= s_tdata[37:6];
            b_reg     <= s_tdata[69:38];
        end
        if (advance)
            out_reg <= exec_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // flags shown with a result are the ones stored by that result
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_reg.flags == flags_reg)
        else $error("result flags differ from stored flags");

    a_err_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        advance && exec_res.error |=> flags_reg == $past(flags_reg))
        else $error("erroneous operation changed the flags");

    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        advance && exec_res.error |-> !exec_res.writes_result && exec_res.result == 32'd0)
        else $error("erroneous operation produced a result");

    a_flags_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without a transaction executing");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

// File: sv/x86alu_exec.sv
`default_nettype none

module x86alu_exec
    import x86alu_pkg::*;
(
    input  cmd_t        command,
    input  width_t      width_code,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  flags_t      flags_in,
    output exec_res_t   res_out
);

    logic [31:0]        mask;
    logic [31:0]        sign_m;
    logic [5:0]         bits;
    logic [31:0]        a_m;
    logic [31:0]        b_m;
    logic signed [31:0] a_sx;
    logic signed [31:0] b_sx;
    logic [32:0]        sum33;
    logic [32:0]        diff33;
    logic               cin_add;
    logic               cin_sub;
    logic               carry_add;
    logic               borrow_sub;
    logic signed [63:0] prod;
    logic               mul_ov;
    logic [4:0]         n;
    logic [4:0]         rot;
    logic [63:0]        dbl;
    logic [31:0]        rol_v;
    logic [31:0]        ror_v;
    logic [31:0]        res;
    flags_t             fl;

    always_comb
    begin
        unique case (width_code)
            WC_BYTE:
            begin
                mask   = 32'h0000_00FF;
                sign_m = 32'h0000_0080;
                bits   = 6'd8;
                a_sx   = {{24{operand_a[7]}}, operand_a[7:0]};
                b_sx   = {{24{operand_b[7]}}, operand_b[7:0]};
                rot    = {2'b00, operand_b[2:0]};
                dbl    = {48'd0, operand_a[7:0], operand_a[7:0]};
            end
            WC_WORD:
            begin
                mask   = 32'h0000_FFFF;
                sign_m = 32'h0000_8000;
                bits   = 6'd16;
                a_sx   = {{16{operand_a[15]}}, operand_a[15:0]};
                b_sx   = {{16{operand_b[15]}}, operand_b[15:0]};
                rot    = {1'b0, operand_b[3:0]};
                dbl    = {32'd0, operand_a[15:0], operand_a[15:0]};
            end
            default:
            begin
                mask   = 32'hFFFF_FFFF;
                sign_m = 32'h8000_0000;
                bits   = 6'd32;
                a_sx   = operand_a;
                b_sx   = operand_b;
                rot    = operand_b[4:0];
                dbl    = {operand_a, operand_a};
            end
        endcase
    end

    assign a_m     = operand_a & mask;
    assign b_m     = operand_b & mask;
    assign n       = operand_b[4:0];
    assign cin_add = (command == CMD_ADC) & flags_in.cf;
    assign cin_sub = (command == CMD_SBB) & flags_in.cf;
    assign sum33   = {1'b0, a_m} + {1'b0, b_m} + {32'd0, cin_add};
    assign diff33  = {1'b0, a_m} - {1'b0, b_m} - {32'd0, cin_sub};
    assign prod    = a_sx * b_sx;

    // rotate inside a doubled copy of the operand
    assign rol_v = 32'((dbl << rot) >> bits) & mask;
    assign ror_v = 32'(dbl >> rot) & mask;

    always_comb
    begin
        unique case (width_code)
            WC_BYTE:
            begin
                carry_add  = sum33[8];
                borrow_sub = diff33[8];
                mul_ov     = 1'b0;
            end
            WC_WORD:
            begin
                carry_add  = sum33[16];
                borrow_sub = diff33[16];
                mul_ov     = prod[63:15] != {49{prod[15]}};
            end
            default:
            begin
                carry_add  = sum33[32];
                borrow_sub = diff33[32];
                mul_ov     = prod[63:31] != {33{prod[31]}};
            end
        endcase
    end

    always_comb
    begin
        fl  = flags_in;
        res = 32'd0;
        res_out.error         = 1'b0;
        res_out.writes_result = 1'b1;
        if (width_code == WC_BAD || (command == CMD_IMUL && width_code == WC_BYTE))
        begin
            res_out.error         = 1'b1;
            res_out.writes_result = 1'b0;
        end
        else
        begin
            case (command) inside
                CMD_ADD, CMD_ADC:
                begin
                    res   = sum33[31:0] & mask;
                    fl.cf = carry_add;
                    fl.of = |((a_m ^ res) & (b_m ^ res) & sign_m);
                    fl.zf = res == 32'd0;
                    fl.sf = |(res & sign_m);
                    fl.pf = ~^res[7:0];
                end
                CMD_SUB, CMD_SBB, CMD_CMP:
                begin
                    res   = diff33[31:0] & mask;
                    fl.cf = borrow_sub;
                    fl.of = |((a_m ^ b_m) & (a_m ^ res) & sign_m);
                    fl.zf = res == 32'd0;
                    fl.sf = |(res & sign_m);
                    fl.pf = ~^res[7:0];
                end
                CMD_AND, CMD_TEST, CMD_OR, CMD_XOR:
                begin
                    if (command == CMD_OR)
                        res = a_m | b_m;
                    else if (command == CMD_XOR)
                        res = a_m ^ b_m;
                    else
                        res = a_m & b_m;
                    fl.cf = 1'b0;
                    fl.of = 1'b0;
                    fl.zf = res == 32'd0;
                    fl.sf = |(res & sign_m);
                    fl.pf = ~^res[7:0];
                end
                CMD_NOT:
                begin
                    res = ~a_m & mask;
                end
                CMD_ROL, CMD_ROR:
                begin
                    res = a_m;
                    if (n != 5'd0)
                    begin
                        if (command == CMD_ROL)
                        begin
                            res   = rol_v;
                            fl.cf = res[0];
                        end
                        else
                        begin
                            res   = ror_v;
                            fl.cf = |(res & sign_m);
                        end
                    end
                end
                CMD_SAR, CMD_SHL, CMD_SHR:
                begin
                    res = a_m;
                    if (n != 5'd0)
                    begin
                        if (command == CMD_SHL)
                            res = (a_m << n) & mask;
                        else if (command == CMD_SHR)
                            res = a_m >> n;
                        else
                            res = 32'(a_sx >>> n) & mask;
                        fl.zf = res == 32'd0;
                        fl.pf = ~^res[7:0];
                    end
                end
                default:
                begin
                    res   = prod[31:0] & mask;
                    fl.cf = mul_ov;
                    fl.of = mul_ov;
                    fl.zf = res == 32'd0;
                    fl.sf = |(res & sign_m);
                    fl.pf = ~^res[7:0];
                end
            endcase
            if (command == CMD_CMP || command == CMD_TEST)
            begin
                res                   = 32'd0;
                res_out.writes_result = 1'b0;
            end
        end
        res_out.result = res;
        res_out.flags  = fl;
    end

endmodule

`default_nettype wire
